FILE: rtl/core/scancode_set1_to_ascii_defines.svh
// assertion macros for the scan-code set 1 decoder
`ifndef SCANCODE_SET1_TO_ASCII_DEFINES_SVH
`define SCANCODE_SET1_TO_ASCII_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SC1A_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sc1a same-cycle check failed");

// next-cycle implication, checked outside reset
`define SC1A_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sc1a next-cycle check failed");

`endif

FILE: rtl/core/sc1a_pkg.sv
// shared types, codes and ascii tables of the scan-code set 1 decoder
package sc1a_pkg;

  localparam int unsigned TableLen = 84;

  localparam logic [7:0] SC_ACK    = 8'hFA;
  localparam logic [7:0] SC_RESEND = 8'hFE;
  localparam logic [7:0] SC_EXT    = 8'hE0;

  localparam logic [6:0] SC_LSHIFT   = 7'h2A;
  localparam logic [6:0] SC_RSHIFT   = 7'h36;
  localparam logic [6:0] SC_CTRL     = 7'h1D;
  localparam logic [6:0] SC_CAPS     = 7'h3A;
  localparam logic [6:0] SC_NUM      = 7'h45;
  localparam logic [6:0] SC_SCROLL   = 7'h46;
  localparam logic [6:0] SC_KP_FIRST = 7'h47;
  localparam logic [6:0] SC_KP_LAST  = 7'h53;
  localparam logic [6:0] SC_UP       = 7'h48;
  localparam logic [6:0] SC_DOWN     = 7'h50;
  localparam logic [6:0] SC_LEFT     = 7'h4B;
  localparam logic [6:0] SC_RIGHT    = 7'h4D;
  localparam logic [6:0] SC_TAB_END  = 7'(TableLen);

  localparam logic [7:0] CASE_OFFSET = 8'h20;

  localparam logic [1:0] CFG_ARROW_UP    = 2'd0;
  localparam logic [1:0] CFG_ARROW_DOWN  = 2'd1;
  localparam logic [1:0] CFG_ARROW_LEFT  = 2'd2;
  localparam logic [1:0] CFG_ARROW_RIGHT = 2'd3;

  typedef enum logic [1:0] {
    REPLY_NONE   = 2'd0,
    REPLY_ACK    = 2'd1,
    REPLY_RESEND = 2'd2
  } reply_kind_t;

  typedef struct packed {
    logic [7:0] up;
    logic [7:0] down;
    logic [7:0] left;
    logic [7:0] right;
  } arrow_codes_t;

  typedef struct packed {
    logic        key_valid;
    logic [7:0]  key_code;
    logic        led_write;
    logic [2:0]  led_bits;
    reply_kind_t reply_kind;
  } key_result_t;

  localparam logic [7:0] PLAIN_TAB [TableLen] = '{
    8'h00, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
    8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
    8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
    8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61, 8'h73,
    8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
    8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
    8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A,
    8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
    8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
    8'h32, 8'h33, 8'h30, 8'h2E
  };

  localparam logic [7:0] SHIFT_TAB [TableLen] = '{
    8'h00, 8'h00, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
    8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
    8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
    8'h6F, 8'h70, 8'h7B, 8'h7D, 8'h0A, 8'h00, 8'h61, 8'h73,
    8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3A,
    8'h22, 8'h7E, 8'h00, 8'h7C, 8'h7A, 8'h78, 8'h63, 8'h76,
    8'h62, 8'h6E, 8'h6D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A,
    8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
    8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
    8'h32, 8'h33, 8'h30, 8'h2E
  };

endpackage

FILE: rtl/core/scancode_set1_to_ascii.sv
// top level of the scan-code set 1 to ascii decoder
// Usage:
//  - input channel: scan_byte with in_valid; a transaction completes on a clock
//    edge with in_valid high and in_stall low
//  - output channel: key_valid, key_code, led_write, led_bits and reply_kind
//    with out_valid; a transaction completes with out_valid high and out_stall
//    low; every input byte gives exactly one output transaction
//  - the byte lands in the input register at its accepting edge, and the table
//    lookup and flag update load the result register when the byte advances
//  - throughput is one byte per cycle without stalls, set by the single decode pass
//  - when the receiver stalls, the result register holds and the input
//    register still takes one more byte; in_stall rises only once both are full
//  - config: cfg_write with cfg_index 0 to 3 sets the up, down, left and right
//    arrow codes; write only while no transaction is in flight
//  - synchronous reset empties both registers, clears the extended, shift,
//    ctrl and lock flags and loads arrow codes 128 to 131
module scancode_set1_to_ascii
  import sc1a_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] scan_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       key_valid,
  output logic [7:0] key_code,
  output logic       led_write,
  output logic [2:0] led_bits,
  output logic [1:0] reply_kind,
  input  logic       cfg_write,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

`include "scancode_set1_to_ascii_defines.svh"

  arrow_codes_t arrows;
  key_result_t  dec_result;
  key_result_t  res;
  logic         s1_valid;
  logic [7:0]   s1_byte;
  logic         out_ready;
  logic         advance;
  logic         in_take;

  assign out_ready = ~out_valid | ~out_stall;
  assign advance   = s1_valid & out_ready;
  assign in_stall  = s1_valid & ~out_ready;
  assign in_take   = in_valid & ~in_stall;

  sc1a_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .arrows    (arrows)
  );

  sc1a_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .scan_byte (s1_byte),
    .arrows    (arrows),
    .result    (dec_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte <= scan_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= dec_result;
    end
  end

  assign key_valid  = res.key_valid;
  assign key_code   = res.key_code;
  assign led_write  = res.led_write;
  assign led_bits   = res.led_bits;
  assign reply_kind = res.reply_kind;

  `SC1A_ASSERT_NOW(a_code_zero_when_invalid, out_valid && !key_valid, key_code == 8'h00)
  `SC1A_ASSERT_NOW(a_reply_no_key, out_valid && reply_kind != REPLY_NONE, !key_valid && !led_write)
  `SC1A_ASSERT_NOW(a_led_no_key, out_valid && led_write, !key_valid)
  `SC1A_ASSERT_NOW(a_stall_only_full, in_stall, out_valid && s1_valid)
  `SC1A_ASSERT_NEXT(a_take_fills_input, in_take, s1_valid)

endmodule

FILE: rtl/core/sc1a_cfg_regs.sv
// arrow key code registers written through the configuration port
module sc1a_cfg_regs
  import sc1a_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_write,
  input  logic [1:0]   cfg_index,
  input  logic [7:0]   cfg_data,
  output arrow_codes_t arrows
);

  always_ff @(posedge clk) begin
    if (rst) begin
      arrows.up    <= 8'd128;
      arrows.down  <= 8'd129;
      arrows.left  <= 8'd130;
      arrows.right <= 8'd131;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_ARROW_UP:    arrows.up    <= cfg_data;
        CFG_ARROW_DOWN:  arrows.down  <= cfg_data;
        CFG_ARROW_LEFT:  arrows.left  <= cfg_data;
        CFG_ARROW_RIGHT: arrows.right <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/core/sc1a_decode.sv
// keyboard state flags and the single-pass decode of one scan byte
module sc1a_decode
  import sc1a_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         advance,
  input  logic [7:0]   scan_byte,
  input  arrow_codes_t arrows,
  output key_result_t  result
);

  typedef struct packed {
    logic extended_pending;
    logic shift_held;
    logic ctrl_held;
    logic caps_on;
    logic num_on;
    logic scroll_on;
  } kb_state_t;

  kb_state_t  state;
  kb_state_t  state_next;
  logic [6:0] code;
  logic       make;
  logic [7:0] chr;
  logic       keypad;

  assign code   = scan_byte[6:0];
  assign make   = ~scan_byte[7];
  assign keypad = (code >= SC_KP_FIRST) && (code <= SC_KP_LAST);

  always_comb begin
    chr = 8'h00;
    if (code < SC_TAB_END) begin
      chr = state.shift_held ? SHIFT_TAB[code] : PLAIN_TAB[code];
    end
  end

  always_comb begin
    state_next        = state;
    result.key_valid  = 1'b0;
    result.key_code   = 8'h00;
    result.led_write  = 1'b0;
    result.reply_kind = REPLY_NONE;
    if (scan_byte == SC_ACK) begin
      result.reply_kind = REPLY_ACK;
    end else if (scan_byte == SC_RESEND) begin
      result.reply_kind = REPLY_RESEND;
    end else if (scan_byte == SC_EXT) begin
      state_next.extended_pending = 1'b1;
    end else if (state.extended_pending) begin
      state_next.extended_pending = 1'b0;
      if (make) begin
        result.key_valid = 1'b1;
        case (code)
          SC_UP:    result.key_code = arrows.up;
          SC_DOWN:  result.key_code = arrows.down;
          SC_LEFT:  result.key_code = arrows.left;
          SC_RIGHT: result.key_code = arrows.right;
          default:  result.key_valid = 1'b0;
        endcase
      end
    end else if (code == SC_LSHIFT || code == SC_RSHIFT) begin
      state_next.shift_held = make;
    end else if (code == SC_CTRL) begin
      state_next.ctrl_held = make;
    end else if (code == SC_CAPS || code == SC_NUM || code == SC_SCROLL) begin
      if (make) begin
        result.led_write = 1'b1;
        case (code)
          SC_CAPS: state_next.caps_on   = ~state.caps_on;
          SC_NUM:  state_next.num_on    = ~state.num_on;
          default: state_next.scroll_on = ~state.scroll_on;
        endcase
      end
    end else if (make && chr != 8'h00) begin
      // keypad digits need num lock
      if (!((chr inside {[8'h30:8'h39]}) && keypad && !state.num_on)) begin
        result.key_valid = 1'b1;
        if ((chr inside {[8'h61:8'h7A]}) && (state.shift_held ^ state.caps_on)) begin
          result.key_code = chr - CASE_OFFSET;
        end else begin
          result.key_code = chr;
        end
      end
    end
    result.led_bits = {state_next.caps_on, state_next.num_on, state_next.scroll_on};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

endmodule
